### design/stq_pkg.sv
// Shared types and constants for the software timer queue.
// Holds the transaction structs, command codes, controller states and control/status structs.
// No dependencies.
package stq_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int TIME_W         = 48;
	localparam int PERIOD_W       = 32;
	localparam int ID_W           = 4;
	localparam int CMD_W          = 2;

	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ARM    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DISARM = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [ID_W-1:0]     timer_id;
		logic [PERIOD_W-1:0] period_ms;
		logic                repeat_req;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] fired_timer;
		logic            still_armed;
		logic            last_event;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIRE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // transaction taken this cycle
		logic tick_go;  // accepted transaction is a tick
		logic scan_rd;  // issue a timer read this cycle
		logic fire;     // end of a scan pass
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic addr_last;
		logic best_valid;
		logic last_evt;
	} dp_stat_t;

endpackage

### design/stq_ctrl.sv
// Controller state machine of the software timer queue.
// Sequences scan passes over the timer bank after each tick; depends on stq_pkg.
module stq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                is_tick,
	input  stq_pkg::dp_stat_t   stat,
	output logic                busy,
	output stq_pkg::ctrl_cmd_t  cmd
);

	stq_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			stq_pkg::ST_IDLE: begin
				if (start && is_tick) begin
					state_nxt = stq_pkg::ST_SCAN;
				end
			end
			stq_pkg::ST_SCAN: begin
				if (stat.addr_last) begin
					state_nxt = stq_pkg::ST_DRAIN;
				end
			end
			stq_pkg::ST_DRAIN: begin
				state_nxt = stq_pkg::ST_FIRE;
			end
			stq_pkg::ST_FIRE: begin
				if (!stat.best_valid || stat.last_evt) begin
					state_nxt = stq_pkg::ST_IDLE;
				end else begin
					state_nxt = stq_pkg::ST_SCAN;
				end
			end
			default: begin
				state_nxt = stq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = (state_q != stq_pkg::ST_IDLE);
		cmd.accept  = start && (state_q == stq_pkg::ST_IDLE);
		cmd.tick_go = cmd.accept && is_tick;
		cmd.scan_rd = (state_q == stq_pkg::ST_SCAN);
		cmd.fire    = (state_q == stq_pkg::ST_FIRE);
	end

endmodule

### design/stq_dp.sv
// Datapath of the software timer queue: time counter, timer memories, flags,
// scan pipeline with minimum-deadline tracker and result register. Depends on stq_pkg.
module stq_dp #(
	parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stq_pkg::ctrl_cmd_t cmd,
	input  stq_pkg::req_t      request,
	output stq_pkg::dp_stat_t  stat,
	output logic               result_valid,
	output stq_pkg::rsp_t      result
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);

	logic [stq_pkg::TIME_W-1:0]   now_q;
	logic [stq_pkg::TIME_W-1:0]   dl_mem  [NUM_TIMERS];
	logic [stq_pkg::PERIOD_W-1:0] per_mem [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]        queued_q, repeat_q, done_q;

	logic [IDX_W-1:0]             addr_q;
	logic                         rd_valid_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic [stq_pkg::TIME_W-1:0]   dl_s1;
	logic [stq_pkg::PERIOD_W-1:0] per_s1;

	logic                         best_v_q, best_rep_q, first_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic [stq_pkg::TIME_W-1:0]   best_dl_q;
	logic [stq_pkg::PERIOD_W-1:0] best_per_q;
	logic [CNT_W-1:0]             cnt_q, rem_q, rem;

	logic                         id_ok, do_start, do_stop, elig, pass_clr, fire_hit;
	logic [IDX_W-1:0]             id_idx;

	assign id_ok    = (32'(request.timer_id) < NUM_TIMERS);
	assign id_idx   = IDX_W'(request.timer_id);
	assign do_start = cmd.accept && id_ok && (request.command == stq_pkg::CMD_ARM);
	assign do_stop  = cmd.accept && id_ok && (request.command == stq_pkg::CMD_DISARM);

	// due, not yet fired this tick
	assign elig = rd_valid_s1 && queued_q[idx_s1] && !done_q[idx_s1] && (dl_s1 <= now_q);

	assign fire_hit = cmd.fire && best_v_q;
	assign rem      = first_q ? cnt_q : rem_q;

	always_comb begin
		stat.addr_last  = (addr_q == IDX_W'(NUM_TIMERS - 1));
		stat.best_valid = best_v_q;
		stat.last_evt   = (rem == CNT_W'(1));
	end

	assign pass_clr = cmd.tick_go || (fire_hit && !stat.last_evt);

	// timer memories: one write port, registered read
	always_ff @(posedge clk) begin
		if (do_start) begin
			dl_mem[id_idx]  <= now_q + stq_pkg::TIME_W'(request.period_ms);
			per_mem[id_idx] <= request.period_ms;
		end else if (fire_hit && best_rep_q) begin
			dl_mem[best_idx_q] <= best_dl_q + stq_pkg::TIME_W'(best_per_q);
		end
		dl_s1  <= dl_mem[addr_q];
		per_s1 <= per_mem[addr_q];
		idx_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q        <= '0;
			queued_q     <= '0;
			repeat_q     <= '0;
			done_q       <= '0;
			addr_q       <= '0;
			rd_valid_s1  <= 1'b0;
			best_v_q     <= 1'b0;
			first_q      <= 1'b0;
			cnt_q        <= '0;
			rem_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			rd_valid_s1  <= cmd.scan_rd;
			result_valid <= fire_hit;
			if (do_start) begin
				queued_q[id_idx] <= 1'b1;
				repeat_q[id_idx] <= request.repeat_req;
			end else if (do_stop) begin
				queued_q[id_idx] <= 1'b0;
			end
			if (cmd.tick_go) begin
				now_q  <= now_q + 1'b1;
				done_q <= '0;
			end
			if (cmd.scan_rd) begin
				addr_q <= addr_q + 1'b1;
			end
			if (elig) begin
				if (!best_v_q || (dl_s1 < best_dl_q)) begin
					best_v_q <= 1'b1;
				end
				if (first_q) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (fire_hit) begin
				done_q[best_idx_q] <= 1'b1;
				rem_q <= rem - 1'b1;
				if (!best_rep_q) begin
					queued_q[best_idx_q] <= 1'b0;
				end
			end
			if (pass_clr) begin
				addr_q   <= '0;
				best_v_q <= 1'b0;
				first_q  <= cmd.tick_go;
				if (cmd.tick_go) begin
					cnt_q <= '0;
				end
			end
		end
	end

	// best candidate payload; strict less-than keeps the lower index on ties
	always_ff @(posedge clk) begin
		if (elig && (!best_v_q || (dl_s1 < best_dl_q))) begin
			best_idx_q <= idx_s1;
			best_dl_q  <= dl_s1;
			best_per_q <= per_s1;
			best_rep_q <= repeat_q[idx_s1];
		end
		if (fire_hit) begin
			result.fired_timer <= stq_pkg::ID_W'(best_idx_q);
			result.still_armed <= best_rep_q;
			result.last_event  <= stat.last_evt;
		end
	end

	a_done_set: assert property (@(posedge clk) disable iff (!arst_n)
		fire_hit |=> done_q[$past(best_idx_q)])
		else $error("fired timer not marked done");

	a_oneshot_dq: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_hit && !best_rep_q) |=> !queued_q[$past(best_idx_q)])
		else $error("one-shot timer still queued after firing");

	a_now_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.tick_go |=> $stable(now_q))
		else $error("time advanced without a tick");

	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(cmd.fire))
		else $error("result strobe outside pass end");

endmodule

### design/software_timer_queue_core.sv
// Top level of the software timer queue: controller plus datapath.
// Depends on stq_pkg, stq_ctrl, stq_dp.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------
//  request   | start & !busy accepts        | stq_pkg::req_t
//  result    | result_valid, one cycle      | stq_pkg::rsp_t
//
// Start and stop are accepted only while idle and need no scan pass. A tick runs one
// pass per expiry event it gives (at least one pass): each event is one full scan
// of the timer memories, one entry read per cycle, to find the earliest due deadline.
// Results come out in the cycle after each pass ends; the receiver cannot stall them.
// Reset clears time, queued and repeat flags; the timer memories need no clearing.
module software_timer_queue_core #(
	parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  stq_pkg::req_t request,
	output logic          result_valid,
	output stq_pkg::rsp_t result
);

	stq_pkg::ctrl_cmd_t cmd;
	stq_pkg::dp_stat_t  stat;
	logic               is_tick;

	assign is_tick = (request.command == stq_pkg::CMD_TICK);

	stq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.is_tick (is_tick),
		.stat    (stat),
		.busy    (busy),
		.cmd     (cmd)
	);

	stq_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.request      (request),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

### tb/tb_software_timer_queue_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for software_timer_queue_core: directed and random command traffic.
// Checks every expiry transaction against an in-bench timer bank model.
// Depends on stq_pkg and software_timer_queue_core.
module tb_software_timer_queue_core;

	localparam int                           NUM        = stq_pkg::NUM_TIMERS_DEF;
	localparam logic [stq_pkg::CMD_W-1:0]    CMD_UNUSED = 2'd3;
	localparam logic [stq_pkg::PERIOD_W-1:0] PERIOD_MAX = '1;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	stq_pkg::req_t request;
	logic          result_valid;
	stq_pkg::rsp_t result;

	// timer bank model
	bit [stq_pkg::TIME_W-1:0]   model_now;
	bit [stq_pkg::TIME_W-1:0]   model_deadline [NUM];
	bit [stq_pkg::PERIOD_W-1:0] model_period   [NUM];
	bit                         model_repeat   [NUM];
	bit                         model_queued   [NUM];

	stq_pkg::rsp_t expected_expiries[$];
	int            mismatch_count;
	int            sender_idle_pct;

	software_timer_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#6_000_000;
		$display("tb_software_timer_queue_core: errors");
		$finish;
	end

	function automatic stq_pkg::req_t make_cmd(input logic [stq_pkg::CMD_W-1:0] code,
			input int id, input logic [stq_pkg::PERIOD_W-1:0] period, input bit rep);
		stq_pkg::req_t r;
		r.command    = code;
		r.timer_id   = id[stq_pkg::ID_W-1:0];
		r.period_ms  = period;
		r.repeat_req = rep;
		return r;
	endfunction

	// Applies one accepted command to the model; a tick queues its expiries in firing order.
	task automatic advance_timer_model(input stq_pkg::req_t cmd);
		int            due_left;
		int            pick;
		bit [NUM-1:0]  fired;
		stq_pkg::rsp_t ev;
		case (cmd.command)
			stq_pkg::CMD_ARM: begin
				model_period[cmd.timer_id]   = cmd.period_ms;
				model_repeat[cmd.timer_id]   = cmd.repeat_req;
				model_deadline[cmd.timer_id] = model_now + cmd.period_ms;
				model_queued[cmd.timer_id]   = 1'b1;
			end
			stq_pkg::CMD_DISARM: begin
				model_queued[cmd.timer_id] = 1'b0;
			end
			stq_pkg::CMD_TICK: begin
				model_now = model_now + 1'b1;
				due_left  = 0;
				fired     = '0;
				for (int i = 0; i < NUM; i++)
					if (model_queued[i] && model_deadline[i] <= model_now)
						due_left++;
				while (due_left > 0) begin
					pick = -1;
					// strict compare keeps the lower index on equal deadlines
					for (int i = 0; i < NUM; i++)
						if (model_queued[i] && !fired[i] && model_deadline[i] <= model_now &&
								(pick < 0 || model_deadline[i] < model_deadline[pick]))
							pick = i;
					fired[pick] = 1'b1;
					due_left--;
					if (model_repeat[pick])
						model_deadline[pick] = model_deadline[pick] + model_period[pick];
					else
						model_queued[pick] = 1'b0;
					ev.fired_timer = pick[stq_pkg::ID_W-1:0];
					ev.still_armed = model_repeat[pick];
					ev.last_event  = (due_left == 0);
					expected_expiries.push_back(ev);
				end
			end
			default: ;
		endcase
	endtask

	// Drives one transaction, with an optional random gap first, and waits for acceptance.
	task automatic issue_command(input stq_pkg::req_t cmd);
		@(negedge clk);
		if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		start   <= 1'b1;
		request <= cmd;
		do @(posedge clk); while (busy);
		advance_timer_model(cmd);
	endtask

	always @(posedge clk) begin
		stq_pkg::rsp_t want;
		if (arst_n && result_valid) begin
			if (expected_expiries.size() == 0) begin
				$error("unexpected expiry: timer %0d", result.fired_timer);
				mismatch_count++;
			end else begin
				want = expected_expiries.pop_front();
				if (result.fired_timer !== want.fired_timer) begin
					$error("fired_timer: expected %0d, got %0d", want.fired_timer,
						result.fired_timer);
					mismatch_count++;
				end
				if (result.still_armed !== want.still_armed) begin
					$error("still_armed: expected %0d, got %0d", want.still_armed,
						result.still_armed);
					mismatch_count++;
				end
				if (result.last_event !== want.last_event) begin
					$error("last_event: expected %0d, got %0d", want.last_event,
						result.last_event);
					mismatch_count++;
				end
			end
		end
	end

	// quiet tick, stop of an idle timer, unused command, longest and zero periods
	task automatic test_corner_commands();
		issue_command(make_cmd(stq_pkg::CMD_TICK, 0, '0, 1'b0));
		issue_command(make_cmd(stq_pkg::CMD_DISARM, 7, '0, 1'b0));
		issue_command(make_cmd(CMD_UNUSED, 15, PERIOD_MAX, 1'b1));
		issue_command(make_cmd(stq_pkg::CMD_ARM, 0, PERIOD_MAX, 1'b1));
		issue_command(make_cmd(stq_pkg::CMD_ARM, 15, '0, 1'b0));
		issue_command(make_cmd(stq_pkg::CMD_TICK, 0, '0, 1'b0));
	endtask

	// equal deadlines, re-arming a queued timer, stop of a queued timer
	task automatic test_tie_and_rearm();
		issue_command(make_cmd(stq_pkg::CMD_ARM, 9, 32'd2, 1'b1));
		issue_command(make_cmd(stq_pkg::CMD_ARM, 4, 32'd2, 1'b0));
		issue_command(make_cmd(stq_pkg::CMD_TICK, 0, '0, 1'b0));
		issue_command(make_cmd(stq_pkg::CMD_TICK, 0, '0, 1'b0));
		issue_command(make_cmd(stq_pkg::CMD_ARM, 9, 32'd1, 1'b0));
		issue_command(make_cmd(stq_pkg::CMD_DISARM, 9, '0, 1'b0));
	endtask

	// every timer due at once; zero-period repeaters then fire on each tick
	task automatic test_full_bank();
		for (int i = 0; i < NUM; i++)
			issue_command(make_cmd(stq_pkg::CMD_ARM, i, '0, i[0]));
		issue_command(make_cmd(stq_pkg::CMD_TICK, 0, '0, 1'b0));
		issue_command(make_cmd(stq_pkg::CMD_TICK, 0, '0, 1'b0));
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct);
		stq_pkg::req_t cmd;
		int            sel;
		sender_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			cmd.timer_id   = stq_pkg::ID_W'($urandom_range(0, NUM - 1));
			cmd.repeat_req = 1'($urandom_range(0, 1));
			sel = int'($urandom_range(0, 9));
			// mostly short periods so timers keep expiring; some full-range ones
			if (sel < 7)
				cmd.period_ms = $urandom_range(0, 6);
			else if (sel < 9)
				cmd.period_ms = $urandom_range(0, 40);
			else
				cmd.period_ms = $urandom;
			sel = int'($urandom_range(0, 99));
			if (sel < 45)
				cmd.command = stq_pkg::CMD_TICK;
			else if (sel < 80)
				cmd.command = stq_pkg::CMD_ARM;
			else if (sel < 94)
				cmd.command = stq_pkg::CMD_DISARM;
			else
				cmd.command = CMD_UNUSED;
			issue_command(cmd);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		request         = '0;
		mismatch_count  = 0;
		sender_idle_pct = 8;
		model_now       = '0;
		for (int i = 0; i < NUM; i++) begin
			model_deadline[i] = '0;
			model_period[i]   = '0;
			model_repeat[i]   = 1'b0;
			model_queued[i]   = 1'b0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_commands();
		test_tie_and_rearm();
		test_full_bank();
		test_random_traffic(100, 8);
		test_random_traffic(100, 78);
		test_random_traffic(100, 0);

		@(negedge clk);
		start <= 1'b0;
		while (expected_expiries.size() != 0)
			@(posedge clk);
		repeat (320) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_software_timer_queue_core: clean");
		else
			$display("tb_software_timer_queue_core: errors");
		$finish;
	end

endmodule

### filelist.f
design/stq_pkg.sv
design/stq_ctrl.sv
design/stq_dp.sv
design/software_timer_queue_core.sv
tb/tb_software_timer_queue_core.sv
